### rtl/core/sderx_pkg.sv
// ----------------------------------------------------------------------------
// sderx_pkg
// Shared types and codes of the STX/DLE/ETX frame receiver.
// ----------------------------------------------------------------------------
package sderx_pkg;

  // Input operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_OK     = 3'd1;
  localparam logic [2:0] KIND_BADSUM = 3'd2;
  localparam logic [2:0] KIND_SHORT  = 3'd3;
  localparam logic [2:0] KIND_ABORT  = 3'd4;

  // Register indexes (byte address 4*i)
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_END     = 2'd1;
  localparam logic [1:0] REG_ESCAPE  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam int unsigned AddrW = 4;

  localparam logic [7:0]  StartReset   = 8'd15;
  localparam logic [7:0]  EndReset     = 8'd4;
  localparam logic [7:0]  EscapeReset  = 8'd5;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_bytes;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  end_code;
    logic [7:0]  escape_code;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

### rtl/core/sderx_cfg_regs.sv
// ----------------------------------------------------------------------------
// sderx_cfg_regs
// APB-style register file holding the control codes and the idle timeout.
// ----------------------------------------------------------------------------
module sderx_cfg_regs import sderx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code    <= StartReset;
      cfg_q.end_code      <= EndReset;
      cfg_q.escape_code   <= EscapeReset;
      cfg_q.timeout_ticks <= TimeoutReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START:   cfg_q.start_code    <= pwdata[7:0];
        REG_END:     cfg_q.end_code      <= pwdata[7:0];
        REG_ESCAPE:  cfg_q.escape_code   <= pwdata[7:0];
        REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START:   prdata = {24'd0, cfg_q.start_code};
      REG_END:     prdata = {24'd0, cfg_q.end_code};
      REG_ESCAPE:  prdata = {24'd0, cfg_q.escape_code};
      REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/sderx_engine.sv
// ----------------------------------------------------------------------------
// sderx_engine
// Input register and single-pass deframing logic with the receiver state.
// ----------------------------------------------------------------------------
module sderx_engine import sderx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  input  logic      advance_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ONE,
    PH_BODY
  } phase_e;

  logic     in_valid_q;
  in_item_t in_q;
  logic     fire;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic        held_valid_q, held_valid_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] count_q, count_d;
  logic [15:0] idle_q, idle_d;

  logic [7:0]  b;
  logic        is_start;
  logic [15:0] count_inc;

  assign in_stall_o = in_valid_q && !advance_i;
  assign fire       = in_valid_q && advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign b         = in_q.rx_byte;
  assign is_start  = (b == cfg_i.start_code);
  assign count_inc = (count_q < CountMax) ? count_q + 16'd1 : count_q;

  always_comb begin
    phase_d      = phase_q;
    esc_d        = esc_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    sum_d        = sum_q;
    count_d      = count_q;
    idle_d       = idle_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_DATA, data_byte: 8'd0, frame_bytes: count_q};

    priority if (in_q.op == OP_TICK) begin
      if (idle_q < CountMax) idle_d = idle_q + 16'd1;
    end else if (in_q.op == OP_FLUSH) begin
      phase_d      = PH_HUNT;
      esc_d        = 1'b0;
      held_valid_d = 1'b0;
      held_byte_d  = 8'd0;
      sum_d        = 8'd0;
      count_d      = 16'd0;
      idle_d       = 16'd0;
    end else if (in_q.op == OP_BYTE) begin
      idle_d = 16'd0;
      if (phase_q != PH_HUNT && idle_q > cfg_i.timeout_ticks) begin
        // drop the stale partial frame, then hunt with this byte
        esc_d        = 1'b0;
        held_valid_d = 1'b0;
        phase_d      = is_start ? PH_ONE : PH_HUNT;
        if (phase_q == PH_BODY) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ABORT;
        end
      end else begin
        unique case (phase_q)
          PH_ONE: begin
            if (is_start) begin
              phase_d      = PH_BODY;
              esc_d        = 1'b0;
              held_valid_d = 1'b0;
              held_byte_d  = 8'd0;
              sum_d        = 8'd0;
              count_d      = 16'd0;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_BODY: begin
            priority if (!esc_q && b == cfg_i.end_code) begin
              phase_d      = PH_HUNT;
              esc_d        = 1'b0;
              held_valid_d = 1'b0;
              res_valid_o  = 1'b1;
              priority if (!held_valid_q) begin
                res_o.kind = KIND_SHORT;
              end else if (sum_q == 8'd0) begin
                res_o.kind      = KIND_OK;
                res_o.data_byte = held_byte_q;
              end else begin
                res_o.kind      = KIND_BADSUM;
                res_o.data_byte = held_byte_q;
              end
            end else if (!esc_q && b == cfg_i.escape_code) begin
              esc_d = 1'b1;
            end else if (!esc_q && is_start) begin
              phase_d      = PH_ONE;
              esc_d        = 1'b0;
              held_valid_d = 1'b0;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_ABORT;
            end else begin
              // literal byte: release the held one, hold this one
              esc_d        = 1'b0;
              held_byte_d  = b;
              held_valid_d = 1'b1;
              sum_d        = sum_q + b;
              if (held_valid_q) begin
                count_d           = count_inc;
                res_valid_o       = 1'b1;
                res_o.kind        = KIND_DATA;
                res_o.data_byte   = held_byte_q;
                res_o.frame_bytes = count_inc;
              end
            end
          end
          default: begin
            phase_d = is_start ? PH_ONE : PH_HUNT;
          end
        endcase
      end
    end else begin
      // unused op code: nothing to do
    end

    if (!fire) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      esc_q        <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= 8'd0;
      sum_q        <= 8'd0;
      count_q      <= 16'd0;
      idle_q       <= 16'd0;
    end else if (fire) begin
      phase_q      <= phase_d;
      esc_q        <= esc_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
      idle_q       <= idle_d;
    end
  end

endmodule

### rtl/core/sderx_out_reg.sv
// ----------------------------------------------------------------------------
// sderx_out_reg
// Result register between the deframing logic and the output channel.
// ----------------------------------------------------------------------------
module sderx_out_reg import sderx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  out_item_t res_i,
  output logic      advance_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      valid_q;
  out_item_t data_q;

  // free when empty or when the waiting beat leaves this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/core/stx_dle_etx_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// stx_dle_etx_frame_receiver_core
// Byte-stuffed STX/DLE/ETX deframer with additive checksum check.
// ----------------------------------------------------------------------------
// The receiver takes one beat per clock cycle: a raw byte, a time tick or a
// flush. Each beat is captured in an input register, handled in one pass of
// logic against the receiver state and, when it yields a result, lands in the
// result register once that register is free. A payload byte is released one
// byte late, so the checksum byte never appears as data; the end byte yields
// ok, bad checksum or too short, and a start byte inside a frame or a byte
// after an over-long idle gap yields an abort. Input is stalled only while a
// result waits there and the output stalls. The user must write the control
// codes and timeout over the APB port only while idle, which is not enforced.
module stx_dle_etx_frame_receiver_core import sderx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  cfg_t      cfg;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  sderx_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sderx_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sderx_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/sderx_checker.sv
// ----------------------------------------------------------------------------
// sderx_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sderx_checker import sderx_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      pready,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // input backs up only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KIND_ABORT)
    else $error("result kind out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_SHORT || out_data_o.kind == KIND_ABORT)
      |-> out_data_o.data_byte == 8'd0)
    else $error("short or aborted frame carries a data byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind stx_dle_etx_frame_receiver_core sderx_checker u_sderx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
